FILE: src/bli_pkg.sv
// Package for the byte list block: capacity, operation codes, beat structs
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bli_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] position;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       ok;
    logic [6:0] length;
  } out_t;

  typedef enum logic [1:0] {
    RA_IDX_M1,
    RA_IDX_P1,
    RA_POS,
    RA_CNT_M1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_IDX,
    WA_POS,
    WA_CNT
  } wr_sel_e;

  typedef struct packed {
    logic    load;
    logic    check;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    wr_from_mem;
    logic    idx_ld_cnt;
    logic    idx_ld_pos;
    logic    idx_dec;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_cap;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       legal;
    logic       ins_done;
    logic       rem_done;
    logic       out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: src/bli_dp.sv
// Datapath of the byte list: byte memory, length counter, shift index,
// operand registers and the output beat register.
// Depends on bli_pkg.
`default_nettype none

module bli_dp import bli_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire in_t  in_data_i,
  input  wire ctl_t ctl_i,
  output sts_t      sts_o,
  input  wire logic out_stall_i,
  output logic      out_valid_o,
  output out_t      out_data_o
);

  logic [7:0]       mem_q [Capacity];
  logic [7:0]       mem_rdata_q;
  logic [2:0]       op_q;
  logic [5:0]       pos_q;
  logic [7:0]       val_q;
  logic [AddrW-1:0] idx_q;
  logic [CntW-1:0]  cnt_q;
  logic [7:0]       rd_q;
  logic             ok_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [AddrW-1:0] pos_a;
  logic [CntW-1:0]  pos_c;
  logic [CntW-1:0]  idx_p1_c;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             legal;

  assign pos_a    = AddrW'(pos_q);
  assign pos_c    = CntW'(pos_q);
  assign idx_p1_c = CntW'(idx_q) + CntW'(1);

  always_comb begin
    case (op_q)
      OP_PUSH:   legal = (cnt_q < CntW'(Capacity));
      OP_POP:    legal = (cnt_q != '0);
      OP_GET:    legal = (pos_c < cnt_q);
      OP_INSERT: legal = (pos_c <= cnt_q) && (cnt_q < CntW'(Capacity));
      OP_REMOVE: legal = (pos_c < cnt_q);
      default:   legal = 1'b0;
    endcase
  end

  always_comb begin
    case (ctl_i.rd_sel)
      RA_IDX_M1: rd_addr = idx_q - AddrW'(1);
      RA_IDX_P1: rd_addr = idx_q + AddrW'(1);
      RA_POS:    rd_addr = pos_a;
      RA_CNT_M1: rd_addr = AddrW'(cnt_q - CntW'(1));
      default:   rd_addr = idx_q;
    endcase
  end

  always_comb begin
    case (ctl_i.wr_sel)
      WA_IDX:  wr_addr = idx_q;
      WA_POS:  wr_addr = pos_a;
      WA_CNT:  wr_addr = AddrW'(cnt_q);
      default: wr_addr = idx_q;
    endcase
  end

  assign wr_data = ctl_i.wr_from_mem ? mem_rdata_q : val_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (ctl_i.rd_en) begin
      mem_rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q  <= in_data_i.opcode;
      pos_q <= in_data_i.position;
      val_q <= in_data_i.value;
    end
    if (ctl_i.check) begin
      rd_q <= '0;
      ok_q <= legal;
    end else if (ctl_i.rd_cap) begin
      rd_q <= mem_rdata_q;
    end
    if (ctl_i.idx_ld_cnt) begin
      idx_q <= AddrW'(cnt_q);
    end else if (ctl_i.idx_ld_pos) begin
      idx_q <= pos_a;
    end else if (ctl_i.idx_dec) begin
      idx_q <= idx_q - AddrW'(1);
    end else if (ctl_i.idx_inc) begin
      idx_q <= idx_q + AddrW'(1);
    end
    if (ctl_i.out_load) begin
      out_q.read_byte <= rd_q;
      out_q.ok        <= ok_q;
      out_q.length    <= 7'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.cnt_inc) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (ctl_i.cnt_dec) begin
        cnt_q <= cnt_q - CntW'(1);
      end
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.legal    = legal;
  assign sts_o.ins_done = (idx_q == pos_a);
  assign sts_o.rem_done = (idx_p1_c >= cnt_q);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/bli_ctrl.sv
// Controller of the byte list: sequences each operation over the datapath,
// moving each byte for insert and remove with a read state and then a write state.
// Depends on bli_pkg.
`default_nettype none

module bli_ctrl import bli_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output ctl_t      ctl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_CAP    = 3'd2;
  localparam logic [2:0] S_INS    = 3'd3;
  localparam logic [2:0] S_INS_WR = 3'd4;
  localparam logic [2:0] S_REM    = 3'd5;
  localparam logic [2:0] S_REM_WR = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    ctl_o        = '0;
    ctl_o.rd_sel = RA_POS;
    ctl_o.wr_sel = WA_IDX;
    state_d      = state_q;
    in_stall_o   = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl_o.check = 1'b1;
        state_d     = S_FIN;
        if (sts_i.legal) begin
          case (sts_i.op)
            OP_PUSH: begin
              ctl_o.wr_en   = 1'b1;
              ctl_o.wr_sel  = WA_CNT;
              ctl_o.cnt_inc = 1'b1;
            end
            OP_POP: begin
              ctl_o.rd_en  = 1'b1;
              ctl_o.rd_sel = RA_CNT_M1;
              state_d      = S_CAP;
            end
            OP_GET: begin
              ctl_o.rd_en  = 1'b1;
              ctl_o.rd_sel = RA_POS;
              state_d      = S_CAP;
            end
            OP_INSERT: begin
              ctl_o.idx_ld_cnt = 1'b1;
              state_d          = S_INS;
            end
            OP_REMOVE: begin
              ctl_o.rd_en      = 1'b1;
              ctl_o.rd_sel     = RA_POS;
              ctl_o.idx_ld_pos = 1'b1;
              state_d          = S_CAP;
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_CAP: begin
        ctl_o.rd_cap = 1'b1;
        if (sts_i.op == OP_REMOVE) begin
          state_d = S_REM;
        end else begin
          ctl_o.cnt_dec = (sts_i.op == OP_POP);
          state_d       = S_FIN;
        end
      end
      S_INS: begin
        if (sts_i.ins_done) begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wr_sel  = WA_POS;
          ctl_o.cnt_inc = 1'b1;
          state_d       = S_FIN;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RA_IDX_M1;
          state_d      = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ctl_o.wr_en       = 1'b1;
        ctl_o.wr_sel      = WA_IDX;
        ctl_o.wr_from_mem = 1'b1;
        ctl_o.idx_dec     = 1'b1;
        state_d           = S_INS;
      end
      S_REM: begin
        if (sts_i.rem_done) begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_sel = RA_IDX_P1;
          state_d      = S_REM_WR;
        end
      end
      S_REM_WR: begin
        ctl_o.wr_en       = 1'b1;
        ctl_o.wr_sel      = WA_IDX;
        ctl_o.wr_from_mem = 1'b1;
        ctl_o.idx_inc     = 1'b1;
        state_d           = S_REM;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/byte_list_insert_remove.sv
// Path to the output beat: push and refused operations pass S_CHECK and S_FIN, pop
// and get add S_CAP, insert an S_INS/S_INS_WR pair per byte moved and a last S_INS,
// remove S_CAP, an S_REM/S_REM_WR pair per byte moved and a last S_REM. Operations
// run one at a time; a new beat is taken the cycle after the output is loaded.
// Reset: length clears to zero and both channels go idle; memory contents are kept.
// Top level of the byte list; instantiates bli_ctrl and bli_dp, uses bli_pkg.
`default_nettype none

module byte_list_insert_remove import bli_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  ctl_t ctl;
  sts_t sts;

  bli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  bli_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
